### hw/rtl/srt_pkg.sv
// Types, widths and constants shared by the sensor reading table.
package srt_pkg;

  localparam int SLOTS       = 8;
  localparam int WORDS       = 4;
  localparam int MAX_RESULTS = 32;

  localparam int ID_W   = 8;
  localparam int CNT_W  = 3;
  localparam int WORD_W = 32;
  localparam int IDX_W  = 2;
  localparam int NDATA  = 4;

  localparam int WSEL_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int ROT_W  = $clog2(SLOTS + 1);
  localparam int TOT_W  = $clog2(MAX_RESULTS + 1);

  localparam int IN_W    = 144;
  localparam int OUT_W   = 48;
  localparam int OUT_PAD = OUT_W - (WORD_W + ID_W + IDX_W);

  localparam logic [ID_W-1:0]  EMPTY_ID  = 8'hff;
  localparam logic [CNT_W-1:0] WORDS_CNT = CNT_W'(WORDS);
  localparam logic [IDX_W-1:0] WIDX_LAST = IDX_W'(WORDS - 1);
  localparam logic [ROT_W-1:0] ROT_END   = ROT_W'(SLOTS);

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_XMIT  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]               id;
    logic [CNT_W-1:0]              cnt;
    logic [WORDS-1:0][WORD_W-1:0]  words;
  } slot_t;

  typedef struct packed {
    logic [ID_W-1:0]               id;
    logic [CNT_W-1:0]              cnt;
    logic [NDATA-1:0][WORD_W-1:0]  data;
  } item_t;

  typedef struct packed {
    logic valid;
    logic claimed;
  } tok_t;

endpackage

### hw/rtl/sensor_reading_table.sv
// Top level of the sensor reading table: control, cell ring and output register.
//
//   port group   dir  contents
//   s_t*         in   tuser: opcode; tdata: sensor_id, word_count, data_0..data_3
//   m_t*         out  tdata: word, source_id, word_index; tlast: last
//
// A store first compares the sensor id against every slot, then a token walks
// the cell row one cell per cycle. A transmit rotates the ring once: an occupied
// slot sends its words and an empty slot is passed over, after the accept and
// before a closing step, and the rotation stalls while the output register is
// held; an empty table answers with one empty last word. Reset restores every
// slot to empty with zero data at once. New items are taken only between
// operations; the output register lets a store start while the last word still waits.
module sensor_reading_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [7:0] sensor_id, [10:8] word_count, [42:11] data_0, [74:43] data_1,
  // [106:75] data_2, [138:107] data_3, rest zero
  input  logic [srt_pkg::IN_W-1:0]      s_tdata,
  // [0] opcode
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] word, [39:32] source_id, [41:40] word_index, rest zero
  output logic [srt_pkg::OUT_W-1:0]     m_tdata,
  output logic                          m_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_SEND = 3'd3;
  localparam logic [2:0] ST_NONE = 3'd4;

  logic [2:0]                   state;
  srt_pkg::item_t               item;
  logic                         any_hit;
  logic                         tok_start;
  logic [srt_pkg::ROT_W-1:0]    rot_cnt;
  logic [srt_pkg::IDX_W-1:0]    widx;
  logic [srt_pkg::TOT_W-1:0]    emitted;
  logic [srt_pkg::TOT_W-1:0]    total;
  logic                         done_emit;

  logic [srt_pkg::WORD_W-1:0]   out_word;
  logic [srt_pkg::ID_W-1:0]     out_id;
  logic [srt_pkg::IDX_W-1:0]    out_idx;
  logic                         out_last;

  srt_pkg::tok_t                tok_link [srt_pkg::SLOTS+1];
  srt_pkg::slot_t               slots [srt_pkg::SLOTS];
  logic [srt_pkg::SLOTS-1:0]    hits;
  logic [srt_pkg::SLOTS-1:0]    tok_v;

  logic                         s_accept;
  logic                         out_free;
  logic                         occ0;
  logic                         rot_busy;
  logic                         send_emit;
  logic                         send_skip;
  logic                         none_load;
  logic                         wlast;
  logic                         shift_en;
  logic                         emit_last;
  logic [srt_pkg::TOT_W-1:0]    emitted_next;
  logic [srt_pkg::TOT_W-1:0]    total_calc;
  logic [srt_pkg::CNT_W-1:0]    in_cnt;
  logic [srt_pkg::CNT_W-1:0]    sat_cnt;
  logic [srt_pkg::ID_W-1:0]     in_id;
  int                           occ;
  int                           tsum;

  assign tok_link[0] = '{valid: tok_start, claimed: 1'b0};

  for (genvar i = 0; i < srt_pkg::SLOTS; i++) begin : g_cell
    srt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .item     (item),
      .any_hit  (any_hit),
      .tok_in   (tok_link[i]),
      .tok_out  (tok_link[i+1]),
      .shift_en (shift_en),
      .shift_in (slots[(i + 1) % srt_pkg::SLOTS]),
      .slot     (slots[i]),
      .hit      (hits[i])
    );
    assign tok_v[i] = tok_link[i+1].valid;
  end

  always_comb begin
    occ = 0;
    for (int i = 0; i < srt_pkg::SLOTS; i++) begin
      if (slots[i].id != srt_pkg::EMPTY_ID) begin
        occ = occ + 1;
      end
    end
    tsum = occ * srt_pkg::WORDS;
    if (tsum > srt_pkg::MAX_RESULTS) begin
      tsum = srt_pkg::MAX_RESULTS;
    end
    total_calc = tsum[srt_pkg::TOT_W-1:0];
  end

  assign in_id   = s_tdata[7:0];
  assign in_cnt  = s_tdata[10:8];
  assign sat_cnt = (in_cnt > srt_pkg::WORDS_CNT) ? srt_pkg::WORDS_CNT : in_cnt;

  assign s_tready     = (state == ST_IDLE);
  assign s_accept     = s_tvalid & s_tready;
  assign out_free     = ~m_tvalid | m_tready;
  assign occ0         = (slots[0].id != srt_pkg::EMPTY_ID);
  assign rot_busy     = (state == ST_SEND) && (rot_cnt != srt_pkg::ROT_END);
  assign send_emit    = rot_busy && occ0 && !done_emit && out_free;
  assign send_skip    = rot_busy && (!occ0 || done_emit);
  assign wlast        = (widx == srt_pkg::WIDX_LAST);
  assign shift_en     = send_skip | (send_emit & wlast);
  assign none_load    = (state == ST_NONE) && out_free;
  assign emitted_next = emitted + 1'b1;
  assign emit_last    = (emitted_next == total);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      any_hit   <= 1'b0;
      tok_start <= 1'b0;
      rot_cnt   <= '0;
      widx      <= '0;
      emitted   <= '0;
      total     <= '0;
      done_emit <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (send_emit || none_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            if (s_tuser == srt_pkg::OP_XMIT) begin
              rot_cnt   <= '0;
              widx      <= '0;
              emitted   <= '0;
              done_emit <= 1'b0;
              total     <= total_calc;
              state     <= (total_calc == '0) ? ST_NONE : ST_SEND;
            end else if (in_id != srt_pkg::EMPTY_ID) begin
              state <= ST_LOOK;
            end
          end
        end
        ST_LOOK: begin
          any_hit   <= |hits;
          tok_start <= 1'b1;
          state     <= ST_WALK;
        end
        ST_WALK: begin
          tok_start <= 1'b0;
          if (tok_link[srt_pkg::SLOTS].valid) begin
            state <= ST_IDLE;
          end
        end
        ST_SEND: begin
          if (!rot_busy) begin
            state <= ST_IDLE;
          end
          if (send_emit) begin
            emitted   <= emitted_next;
            done_emit <= emit_last;
            widx      <= wlast ? '0 : widx + 1'b1;
          end
          if (send_skip) begin
            widx <= '0;
          end
          if (shift_en) begin
            rot_cnt <= rot_cnt + 1'b1;
          end
        end
        ST_NONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      item.id   <= in_id;
      item.cnt  <= sat_cnt;
      item.data <= s_tdata[138:11];
    end
    if (send_emit) begin
      out_word <= slots[0].words[widx[srt_pkg::WSEL_W-1:0]];
      out_id   <= slots[0].id;
      out_idx  <= widx;
      out_last <= emit_last;
    end else if (none_load) begin
      out_word <= '0;
      out_id   <= srt_pkg::EMPTY_ID;
      out_idx  <= '0;
      out_last <= 1'b1;
    end
  end

  assign m_tdata = {{srt_pkg::OUT_PAD{1'b0}}, out_idx, out_id, out_word};
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  a_tok_single: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_v))
    else $error("more than one store token in the cell row");
  a_tok_walk: assert property (@(posedge clk) disable iff (rst)
    (tok_v != '0) |-> (state == ST_WALK))
    else $error("store token outside a store walk");
  a_hit_unique: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK || state == ST_WALK) |-> $onehot0(hits))
    else $error("sensor id found in more than one slot");
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND) |-> (emitted <= total))
    else $error("transmit emitted more words than counted");
  a_ring_restored: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND && !rot_busy) |-> done_emit)
    else $error("ring rotation finished before the last word");
`endif

endmodule

### hw/rtl/srt_cell.sv
// One table slot: compares against the store item, takes a store token, rotates on transmit.
module srt_cell (
  input  logic           clk,
  input  logic           rst,
  input  srt_pkg::item_t item,
  input  logic           any_hit,
  input  srt_pkg::tok_t  tok_in,
  output srt_pkg::tok_t  tok_out,
  input  logic           shift_en,
  input  srt_pkg::slot_t shift_in,
  output srt_pkg::slot_t slot,
  output logic           hit
);

  srt_pkg::slot_t slot_next;
  logic           empty;
  logic           claim;
  logic           wr;

  always_comb begin
    hit   = (slot.id == item.id);
    empty = (slot.id == srt_pkg::EMPTY_ID);
    claim = tok_in.valid & ~tok_in.claimed & ~any_hit & empty;
    wr    = tok_in.valid & (hit | claim);
    slot_next = slot;
    if (shift_en) begin
      slot_next = shift_in;
    end else if (wr) begin
      if (claim) begin
        slot_next.id       = item.id;
        slot_next.words[0] = '0;
      end
      slot_next.cnt = item.cnt;
      for (int j = 0; j < srt_pkg::WORDS; j++) begin
        if (int'(item.cnt) > j) begin
          slot_next.words[j] = item.data[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.id       <= srt_pkg::EMPTY_ID;
      slot.cnt      <= '0;
      slot.words    <= '0;
      tok_out       <= '0;
    end else begin
      slot          <= slot_next;
      tok_out.valid   <= tok_in.valid;
      tok_out.claimed <= tok_in.claimed | claim;
    end
  end

endmodule
